// ----- rtl/core/awm_pkg.sv -----
package awm_pkg;

   // default sizes
   localparam int MAX_PATTERN_DEF = 64;
   localparam int ALPHABET_DEF    = 256;

   // item function codes
   localparam logic [1:0] FUNC_CLEAR   = 2'd0;
   localparam logic [1:0] FUNC_PATTERN = 2'd1;
   localparam logic [1:0] FUNC_TEXT    = 2'd2;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] symbol;
   } req_payload_type;

   typedef struct packed {
      logic match;
      logic window_full;
      logic rejected;
   } rsp_payload_type;

endpackage

// ----- rtl/core/awm_chan_if.sv -----
interface awm_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/anagram_window_match.sv -----
// channel  dir  payload                             handshake
// req_if   in   func, symbol                        valid/ready
// rsp_if   out  match, window_full, rejected        valid/ready
//
// clear, rejected pattern byte, text with no pattern, unused code: answered from idle
// pattern byte: one read-modify-write of the difference table
// text byte: one symbol while the window fills, two once it is full (leaving, then entering);
//    the difference table takes one read-modify-write per symbol, one at a time
// reset and clear drop all table entries at once through per-entry valid bits
// a new item is taken while the last result waits, as long as it leaves now
module anagram_window_match #(
   parameter int MAX_PATTERN = awm_pkg::MAX_PATTERN_DEF,
   parameter int ALPHABET    = awm_pkg::ALPHABET_DEF
) (
   input  logic              clock,
   input  logic              reset,
   awm_chan_if.sink          req_if,
   awm_chan_if.source        rsp_if
);
   import awm_pkg::*;

   localparam int SymW  = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
   localparam int LenW  = $clog2(MAX_PATTERN + 1);
   localparam int PtrW  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int DiffW = LenW + 1;
   localparam int NzW   = $clog2(ALPHABET + 1);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_RING = 4'b0010,
      S_RD   = 4'b0100,
      S_MW   = 4'b1000
   } state_type;

   typedef logic [SymW-1:0] fold_table_type [256];

   // symbol folding into the alphabet, worked out at elaboration
   function automatic fold_table_type build_fold();
      fold_table_type t;
      for (int i = 0; i < 256; i++) begin
         t[i] = SymW'(i % ALPHABET);
      end
      return t;
   endfunction

   localparam fold_table_type FOLD_TABLE = build_fold();

   // memories
   logic [DiffW-1:0] diff_mem [ALPHABET];
   logic [SymW-1:0]  ring_mem [MAX_PATTERN];

   // registers
   state_type         state_ff, state_in;
   logic [ALPHABET-1:0] tvalid_ff, tvalid_in;
   logic [NzW-1:0]    nz_ff, nz_in;
   logic [PtrW-1:0]   ptr_ff, ptr_in;
   logic [LenW-1:0]   plen_ff, plen_in;
   logic [LenW-1:0]   seen_ff, seen_in;
   logic [SymW-1:0]   addr_ff, addr_in;
   logic [SymW-1:0]   sym_ff, sym_in;
   logic              up_ff, up_in;
   logic              pend_ff, pend_in;
   logic              full_before_ff, full_before_in;
   logic              is_text_ff, is_text_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_data_ff, rsp_data_in;
   logic [DiffW-1:0]  tbl_rd_ff;
   logic              tval_rd_ff;
   logic [SymW-1:0]   ring_rd_ff;

   // combinational
   logic             accept;
   logic [SymW-1:0]  sym_fold;
   logic [SymW-1:0]  tbl_rd_addr;
   logic [DiffW-1:0] old_val;
   logic [DiffW-1:0] new_val;
   logic [NzW-1:0]   nz_after;
   logic             tbl_we;
   logic             ring_we;
   logic [LenW-1:0]  ptr_inc;

   assign req_if.ready   = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_if.ready);
   assign accept         = req_if.valid && req_if.ready;
   assign sym_fold       = FOLD_TABLE[req_if.payload.symbol];
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;
   assign ptr_inc        = LenW'(ptr_ff) + LenW'(1);

   // table read address per step
   always_comb begin
      unique case (state_ff)
         S_IDLE:  tbl_rd_addr = sym_fold;
         S_RING:  tbl_rd_addr = full_before_ff ? ring_rd_ff : sym_ff;
         default: tbl_rd_addr = addr_ff;
      endcase
   end

   // modify step: entry update and nonzero count
   always_comb begin
      old_val = tval_rd_ff ? tbl_rd_ff : '0;
      new_val = up_ff ? (old_val + DiffW'(1)) : (old_val - DiffW'(1));
      if (old_val == '0) begin
         nz_after = nz_ff + NzW'(1);
      end else if (new_val == '0) begin
         nz_after = nz_ff - NzW'(1);
      end else begin
         nz_after = nz_ff;
      end
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      tvalid_in      = tvalid_ff;
      nz_in          = nz_ff;
      ptr_in         = ptr_ff;
      plen_in        = plen_ff;
      seen_in        = seen_ff;
      addr_in        = addr_ff;
      sym_in         = sym_ff;
      up_in          = up_ff;
      pend_in        = pend_ff;
      full_before_in = full_before_ff;
      is_text_in     = is_text_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_data_in    = rsp_data_ff;
      tbl_we         = 1'b0;
      ring_we        = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_if.payload.func)
                  FUNC_CLEAR: begin
                     tvalid_in    = '0;
                     nz_in        = '0;
                     ptr_in       = '0;
                     plen_in      = '0;
                     seen_in      = '0;
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '0;
                  end
                  FUNC_PATTERN: begin
                     if (seen_ff != '0 || plen_ff == LenW'(MAX_PATTERN)) begin
                        rsp_valid_in         = 1'b1;
                        rsp_data_in          = '0;
                        rsp_data_in.rejected = 1'b1;
                     end else begin
                        addr_in    = sym_fold;
                        up_in      = 1'b1;
                        pend_in    = 1'b0;
                        is_text_in = 1'b0;
                        plen_in    = plen_ff + LenW'(1);
                        state_in   = S_MW;
                     end
                  end
                  FUNC_TEXT: begin
                     if (plen_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '0;
                     end else begin
                        ring_we        = 1'b1;
                        sym_in         = sym_fold;
                        is_text_in     = 1'b1;
                        full_before_in = (seen_ff == plen_ff);
                        pend_in        = (seen_ff == plen_ff);
                        ptr_in         = (ptr_inc >= plen_ff) ? '0 : PtrW'(ptr_inc);
                        seen_in        = (seen_ff == plen_ff) ? seen_ff
                                                              : seen_ff + LenW'(1);
                        state_in       = S_RING;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '0;
                  end
               endcase
            end
         end
         S_RING: begin
            // leaving symbol first when the window was already full
            addr_in  = tbl_rd_addr;
            up_in    = full_before_ff;
            state_in = S_MW;
         end
         S_RD: begin
            state_in = S_MW;
         end
         S_MW: begin
            tbl_we             = 1'b1;
            nz_in              = nz_after;
            tvalid_in[addr_ff] = 1'b1;
            if (pend_ff) begin
               pend_in  = 1'b0;
               addr_in  = sym_ff;
               up_in    = 1'b0;
               state_in = S_RD;
            end else begin
               state_in                = S_IDLE;
               rsp_valid_in            = 1'b1;
               rsp_data_in             = '0;
               rsp_data_in.window_full = is_text_ff && (seen_ff == plen_ff);
               rsp_data_in.match       = is_text_ff && (seen_ff == plen_ff)
                                         && (nz_after == '0);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tvalid_ff    <= '0;
         nz_ff        <= '0;
         ptr_ff       <= '0;
         plen_ff      <= '0;
         seen_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tvalid_ff    <= tvalid_in;
         nz_ff        <= nz_in;
         ptr_ff       <= ptr_in;
         plen_ff      <= plen_in;
         seen_ff      <= seen_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      addr_ff        <= addr_in;
      sym_ff         <= sym_in;
      up_ff          <= up_in;
      full_before_ff <= full_before_in;
      is_text_ff     <= is_text_in;
      rsp_data_ff    <= rsp_data_in;
   end

   // difference table, one read and one write port
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         diff_mem[addr_ff] <= new_val;
      end
      tbl_rd_ff  <= diff_mem[tbl_rd_addr];
      tval_rd_ff <= tvalid_ff[tbl_rd_addr];
   end

   // window ring, read of the oldest slot before it is overwritten
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[ptr_ff] <= sym_fold;
      end
      ring_rd_ff <= ring_mem[ptr_ff];
   end

endmodule

// ----- tb/awm_checker.sv -----
`timescale 1ns / 100ps

module awm_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  awm_pkg::req_payload_type req_payload,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  awm_pkg::rsp_payload_type rsp_payload,
   output int                       error_count,
   output int                       pending
);
   import awm_pkg::*;

   localparam int PATTERN_DEPTH = MAX_PATTERN_DEF;
   localparam int SYMBOL_COUNT  = ALPHABET_DEF;

   // shadow of the search state
   logic signed [7:0] tally [SYMBOL_COUNT];
   logic [8:0]        nonzero_tally;
   logic [7:0]        window_ring [PATTERN_DEPTH];
   logic [5:0]        ring_ptr;
   logic [6:0]        pattern_len;
   logic [6:0]        text_seen;

   rsp_payload_type   verdict_queue [$];

   // drop pattern and text
   function automatic void clear_search();
      for (int i = 0; i < SYMBOL_COUNT; i++) begin
         tally[i] = '0;
      end
      nonzero_tally = '0;
      ring_ptr      = '0;
      pattern_len   = '0;
      text_seen     = '0;
   endfunction

   // move one tally entry by +1 or -1, tracking the nonzero count
   function automatic void adjust_tally(input logic [7:0] sym, input logic signed [7:0] delta);
      logic signed [7:0] old_count;
      logic signed [7:0] new_count;
      old_count = tally[sym];
      new_count = old_count + delta;
      if (old_count == 0 && new_count != 0) begin
         nonzero_tally = nonzero_tally + 9'd1;
      end else if (old_count != 0 && new_count == 0) begin
         nonzero_tally = nonzero_tally - 9'd1;
      end
      tally[sym] = new_count;
   endfunction

   // expected verdict for one item, advancing the shadow state
   function automatic rsp_payload_type window_verdict(input req_payload_type item);
      rsp_payload_type verdict;
      int              next_ptr;
      verdict = '0;
      case (item.func)
         FUNC_CLEAR: begin
            clear_search();
         end
         FUNC_PATTERN: begin
            if (text_seen != 0 || pattern_len >= PATTERN_DEPTH) begin
               verdict.rejected = 1'b1;
            end else begin
               adjust_tally(item.symbol, 8'sd1);
               pattern_len = pattern_len + 7'd1;
            end
         end
         FUNC_TEXT: begin
            if (pattern_len != 0) begin
               // leaving symbol goes back, entering symbol is taken out
               if (text_seen >= pattern_len) begin
                  adjust_tally(window_ring[ring_ptr], 8'sd1);
               end
               adjust_tally(item.symbol, -8'sd1);
               window_ring[ring_ptr] = item.symbol;
               next_ptr = int'(ring_ptr) + 1;
               if (next_ptr >= int'(pattern_len)) begin
                  next_ptr = 0;
               end
               ring_ptr = next_ptr[5:0];
               if (text_seen < pattern_len) begin
                  text_seen = text_seen + 7'd1;
               end
               if (text_seen >= pattern_len) begin
                  verdict.window_full = 1'b1;
                  verdict.match       = (nonzero_tally == 0);
               end
            end
         end
         default: begin
         end
      endcase
      return verdict;
   endfunction

   function automatic int field_differs(input string field, input logic want, input logic got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %b, actual %b", $time, field, want, got);
         return 1;
      end
      return 0;
   endfunction

   // compare results against the oldest verdict, then log new items
   always @(posedge clock) begin
      rsp_payload_type want;
      rsp_payload_type logged;
      if (reset) begin
         clear_search();
         verdict_queue.delete();
         error_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (verdict_queue.size() == 0) begin
               $display("%0t ns: unexpected result, expected none, actual %b",
                        $time, rsp_payload);
               error_count <= error_count + 1;
            end else begin
               want = verdict_queue.pop_front();
               error_count <= error_count
                  + field_differs("match", want.match, rsp_payload.match)
                  + field_differs("window_full", want.window_full, rsp_payload.window_full)
                  + field_differs("rejected", want.rejected, rsp_payload.rejected);
            end
         end
         if (req_valid && req_ready) begin
            logged        = window_verdict(req_payload);
            verdict_queue = {verdict_queue, logged};
         end
      end
      pending <= verdict_queue.size();
   end

endmodule

// ----- tb/tb_anagram_window_match.sv -----
`timescale 1ns / 100ps

module tb_anagram_window_match;
   import awm_pkg::*;

   localparam logic [1:0] FUNC_UNUSED  = 2'd3;
   localparam int         PHASE_ITEMS  = 350;
   localparam int         HOLD_CYCLES  = 300;
   localparam int         QUIET_LIMIT  = 2000;
   localparam int         DRAIN_CYCLES = 40;

   logic clock;
   logic reset;

   awm_chan_if #(.payload_type(req_payload_type)) req_chan ();
   awm_chan_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   int error_count;
   int pending;
   int send_idle_pct;
   int recv_stall_pct;
   int hold_requests;
   int counted_items;

   anagram_window_match i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_chan),
      .rsp_if (rsp_chan)
   );

   awm_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_ready   (req_chan.ready),
      .req_payload (req_chan.payload),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_payload (rsp_chan.payload),
      .error_count (error_count),
      .pending     (pending)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // result side: random stalls plus requested long hold-offs
   initial begin
      int holds_served;
      int hold_left;
      holds_served  = 0;
      hold_left     = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // watchdog on cycles with no item moving
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles = quiet_cycles + 1;
         end
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   // offer one item after random idle cycles, return at the falling edge after accept
   task automatic send_item(input logic [1:0] func, input logic [7:0] symbol, input bit counted);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.payload.func   <= func;
      req_chan.payload.symbol <= symbol;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
      if (counted) begin
         counted_items = counted_items + 1;
      end
      @(negedge clock);
   endtask

   function automatic int pick_pattern_len();
      int roll;
      roll = $urandom_range(99);
      if (roll < 4) begin
         return 0;
      end else if (roll < 80) begin
         return $urandom_range(6, 1);
      end else if (roll < 95) begin
         return $urandom_range(20, 7);
      end
      return $urandom_range(MAX_PATTERN_DEF + 2, MAX_PATTERN_DEF - 4);
   endfunction

   // clear, load a pattern, stream text drawn mostly from the pattern
   task automatic run_search(input int pat_len, input int text_len);
      logic [7:0] pattern [$];
      logic [7:0] base;
      logic [7:0] sym;
      bit         narrow;
      int         roll;
      base   = 8'($urandom_range(255));
      narrow = ($urandom_range(3) != 0);
      send_item(FUNC_CLEAR, 8'($urandom_range(255)), 1'b1);
      for (int k = 0; k < pat_len; k++) begin
         sym = narrow ? base + 8'($urandom_range(3)) : 8'($urandom_range(255));
         if (pattern.size() < MAX_PATTERN_DEF) begin
            pattern = {pattern, sym};
         end
         send_item(FUNC_PATTERN, sym, 1'b1);
      end
      for (int k = 0; k < text_len; k++) begin
         roll = $urandom_range(99);
         if (roll < 4) begin
            // late pattern byte
            send_item(FUNC_PATTERN, 8'($urandom_range(255)), 1'b0);
         end else if (roll < 7) begin
            send_item(FUNC_UNUSED, 8'($urandom_range(255)), 1'b0);
         end else begin
            if (roll < 75 && pattern.size() != 0) begin
               sym = pattern[$urandom_range(pattern.size() - 1)];
            end else if (narrow) begin
               sym = base + 8'($urandom_range(3));
            end else begin
               sym = 8'($urandom_range(255));
            end
            send_item(FUNC_TEXT, sym, pat_len != 0);
         end
      end
   endtask

   // stimulus
   initial begin
      int pat_len;
      int phase_start;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      reset            = 1'b1;
      send_idle_pct    = 0;
      recv_stall_pct   = 0;
      hold_requests    = 0;
      counted_items    = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // text with no pattern, unused code
      send_item(FUNC_TEXT, 8'h00, 1'b1);
      send_item(FUNC_UNUSED, 8'hFF, 1'b1);
      // three byte pattern including the symbol extremes
      send_item(FUNC_PATTERN, 8'h00, 1'b1);
      send_item(FUNC_PATTERN, 8'hFF, 1'b1);
      send_item(FUNC_PATTERN, 8'hA5, 1'b1);
      // partial window, then sliding matches and misses
      send_item(FUNC_TEXT, 8'hFF, 1'b1);
      send_item(FUNC_TEXT, 8'h00, 1'b1);
      send_item(FUNC_TEXT, 8'hA5, 1'b1);
      send_item(FUNC_TEXT, 8'h5A, 1'b1);
      send_item(FUNC_TEXT, 8'hFF, 1'b1);
      send_item(FUNC_TEXT, 8'h00, 1'b1);
      send_item(FUNC_TEXT, 8'hA5, 1'b1);
      // pattern byte after text
      send_item(FUNC_PATTERN, 8'h11, 1'b1);
      // clear with a nonzero symbol, then text with an empty pattern
      send_item(FUNC_CLEAR, 8'hFF, 1'b1);
      send_item(FUNC_TEXT, 8'h80, 1'b1);
      // single byte pattern
      send_item(FUNC_PATTERN, 8'h7F, 1'b1);
      send_item(FUNC_TEXT, 8'h7F, 1'b1);
      send_item(FUNC_TEXT, 8'h7F, 1'b1);
      send_item(FUNC_TEXT, 8'h80, 1'b1);
      send_item(FUNC_CLEAR, 8'h00, 1'b1);
      // pattern past full
      run_search(MAX_PATTERN_DEF + 2, 2 * MAX_PATTERN_DEF + 10);

      // random searches across idling phases
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
            default: begin send_idle_pct = 26; recv_stall_pct = 26; end
         endcase
         phase_start = counted_items;
         while (counted_items - phase_start < PHASE_ITEMS) begin
            // long receiver hold-off while items keep coming
            if (phase == 0 && hold_requests == 0 && counted_items - phase_start > 100) begin
               hold_requests = hold_requests + 1;
            end
            pat_len = pick_pattern_len();
            run_search(pat_len, pat_len + $urandom_range(2 * pat_len + 12));
         end
      end
      req_chan.valid <= 1'b0;

      // drain and verdict
      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
